FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
// Each macro expects clk in scope where used; SDX_ASSERT also needs rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is applied.
`define SDX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define SDX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/sdx_pkg.sv
// ----------------------------------------------------------------------------
// sdx_pkg
// Types, character constants and the letter class table of the Soundex encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sdx_pkg;

  typedef logic [7:0] sdx_byte_t;

  typedef struct packed {
    sdx_byte_t ch;
    logic      last;
    logic      empty_word;
  } sdx_item_t;

  typedef struct packed {
    sdx_byte_t letter;
    sdx_byte_t code_one;
    sdx_byte_t code_two;
    sdx_byte_t code_three;
  } sdx_result_t;

  localparam int unsigned SDX_SLOTS = 3;

  localparam sdx_byte_t CLS_1     = 8'h31;  // '1'
  localparam sdx_byte_t CLS_2     = 8'h32;  // '2'
  localparam sdx_byte_t CLS_3     = 8'h33;  // '3'
  localparam sdx_byte_t CLS_4     = 8'h34;  // '4'
  localparam sdx_byte_t CLS_5     = 8'h35;  // '5'
  localparam sdx_byte_t CLS_6     = 8'h36;  // '6'
  localparam sdx_byte_t CLS_VOWEL = 8'h61;  // 'a'
  localparam sdx_byte_t CLS_SKIP  = 8'h68;  // 'h'
  localparam sdx_byte_t CLS_BAD   = 8'h3F;  // '?'
  localparam sdx_byte_t PAD_CHAR  = 8'h30;  // '0'

  localparam sdx_byte_t PRINT_LO  = 8'h20;
  localparam sdx_byte_t PRINT_HI  = 8'h7E;
  localparam sdx_byte_t UPPER_A   = 8'h41;
  localparam sdx_byte_t UPPER_Z   = 8'h5A;
  localparam sdx_byte_t LOWER_A   = 8'h61;
  localparam sdx_byte_t LOWER_Z   = 8'h7A;
  localparam sdx_byte_t CASE_BIT  = 8'h20;

  function automatic sdx_byte_t sdx_class(input sdx_byte_t c);
    sdx_byte_t l;
    sdx_byte_t r;
    l = (c >= UPPER_A && c <= UPPER_Z) ? (c | CASE_BIT) : c;
    case (l)
      8'h62, 8'h66, 8'h70, 8'h76:                       r = CLS_1;  // b f p v
      8'h63, 8'h67, 8'h6A, 8'h6B,
      8'h71, 8'h73, 8'h78, 8'h7A:                       r = CLS_2;  // c g j k q s x z
      8'h64, 8'h74:                                     r = CLS_3;  // d t
      8'h6C:                                            r = CLS_4;  // l
      8'h6D, 8'h6E:                                     r = CLS_5;  // m n
      8'h72:                                            r = CLS_6;  // r
      8'h61, 8'h65, 8'h69, 8'h6F, 8'h75, 8'h79:         r = CLS_VOWEL;
      default:                                          r = CLS_SKIP;
    endcase
    if (c < PRINT_LO || c > PRINT_HI) begin
      r = CLS_BAD;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/sdx_if.sv
// ----------------------------------------------------------------------------
// sdx_if
// Valid/ready channels of the Soundex encoder: byte input and code output.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  logic       empty_word;

  modport source (output valid, output ch, output last, output empty_word, input ready);
  modport sink   (input valid, input ch, input last, input empty_word, output ready);
endinterface

interface sdx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] letter;
  logic [7:0] code_one;
  logic [7:0] code_two;
  logic [7:0] code_three;

  modport source (output valid, output letter, output code_one, output code_two,
                  output code_three, input ready);
  modport sink   (input valid, input letter, input code_one, input code_two,
                  input code_three, output ready);
endinterface

`default_nettype wire

FILE: sv/soundex_encoder.sv
// ----------------------------------------------------------------------------
// soundex_encoder
// Four-character Soundex code of a word streamed one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  : one byte per transfer (ch), last marks the final byte of a word,
//             empty_word gives an all-zero code and drops any partial word.
//   out_bus : one code per word (letter, code_one..code_three), handed over
//             on the transfer that carries last or empty_word.
//   Path    : a byte is held in the input register and is folded into the
//             word state as it leaves; the code of a final byte is loaded
//             into the result register at that same edge and is offered
//             on out_bus from there.
//   Rate    : one byte per cycle unless a final byte stalls (see Stall), set
//             by the combinational class lookup and state update.
//   Stall   : while a code waits in the result register, non-final bytes keep
//             flowing; a final byte waits in the input register until the
//             result register frees, and in_bus.ready then drops.
//   Reset   : rst_n low clears both valid flags and the core's in-word flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module soundex_encoder import sdx_pkg::*; #(
  parameter int unsigned CODE_DIGITS = 3
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sdx_in_if.sink    in_bus,
  sdx_out_if.source out_bus
);

  logic        s1_valid;
  sdx_item_t   s1_item;
  logic        s1_emit;
  logic        s1_take;
  logic        out_space;
  sdx_result_t core_res;

  assign s1_emit = s1_item.last || s1_item.empty_word;
  assign s1_take = s1_valid && (!s1_emit || out_space);

  sdx_in_stage u_in (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .take   (s1_take),
    .valid  (s1_valid),
    .item   (s1_item)
  );

  sdx_core #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_take),
    .item  (s1_item),
    .res   (core_res)
  );

  sdx_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (s1_take && s1_emit),
    .res     (core_res),
    .space   (out_space),
    .out_bus (out_bus)
  );

  `SDX_ASSERT(a_code_follows_word, s1_take && s1_emit |=> out_bus.valid, "code lost")

endmodule

`default_nettype wire

FILE: sv/sdx_in_stage.sv
// ----------------------------------------------------------------------------
// sdx_in_stage
// Input register: captures one byte transfer and holds it until consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module sdx_in_stage import sdx_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  sdx_in_if.sink         in_bus,
  input  wire logic      take,
  output logic           valid,
  output sdx_item_t      item
);

  logic      valid_r;
  logic      valid_nxt;
  sdx_item_t item_r;
  logic      load;

  assign in_bus.ready = !valid_r || take;
  assign load         = in_bus.valid && in_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= '{ch: in_bus.ch, last: in_bus.last, empty_word: in_bus.empty_word};
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

`default_nettype wire

FILE: sv/sdx_core.sv
// ----------------------------------------------------------------------------
// sdx_core
// Word state and code builder: classes one byte, merges repeats, forms result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sdx_core import sdx_pkg::*; #(
  parameter int unsigned CODE_DIGITS = 3
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire sdx_item_t item,
  output sdx_result_t    res
);

  localparam int unsigned CW = $clog2(CODE_DIGITS + 1);

  logic              in_word_r, in_word_nxt;
  sdx_byte_t         letter_r,  letter_nxt;
  sdx_byte_t         prev_r,    prev_nxt;
  logic [CW-1:0]     count_r,   count_nxt;
  sdx_byte_t [SDX_SLOTS-1:0] codes_r, codes_nxt;

  sdx_byte_t cls;
  logic      emit;

  assign cls  = sdx_class(item.ch);
  assign emit = item.last || item.empty_word;

  always_comb begin
    in_word_nxt = in_word_r;
    letter_nxt  = letter_r;
    prev_nxt    = prev_r;
    count_nxt   = count_r;
    codes_nxt   = codes_r;
    res         = '0;
    if (!item.empty_word) begin
      if (!in_word_r) begin
        in_word_nxt = 1'b1;
        if (cls == CLS_BAD) begin
          letter_nxt = item.ch;
        end else if (item.ch >= LOWER_A && item.ch <= LOWER_Z) begin
          letter_nxt = item.ch & ~CASE_BIT;
        end else begin
          letter_nxt = item.ch;
        end
        prev_nxt  = cls;
        count_nxt = '0;
        for (int k = 0; k < SDX_SLOTS; k++) begin
          codes_nxt[k] = PAD_CHAR;
        end
      end else if (letter_r != '0 && count_r < CW'(CODE_DIGITS)) begin
        if (cls == CLS_VOWEL) begin
          prev_nxt = cls;
        end else if (cls != CLS_SKIP && cls != prev_r) begin
          for (int k = 0; k < SDX_SLOTS; k++) begin
            if (4'(count_r) == 4'(k)) begin
              codes_nxt[k] = cls;
            end
          end
          count_nxt = count_r + 1'b1;
          prev_nxt  = cls;
        end
      end
      if (letter_nxt != '0) begin
        res = '{letter: letter_nxt, code_one: codes_nxt[0], code_two: codes_nxt[1],
                code_three: codes_nxt[2]};
      end
    end
    if (emit) begin
      in_word_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_word_r <= 1'b0;
    end else if (fire) begin
      in_word_r <= in_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      letter_r <= letter_nxt;
      prev_r   <= prev_nxt;
      count_r  <= count_nxt;
      codes_r  <= codes_nxt;
    end
  end

  `SDX_ASSERT(a_empty_gives_zero, fire && item.empty_word |-> res == '0, "empty word not zero")
  `SDX_ASSERT(a_word_closed, fire && emit |=> !in_word_r, "word state open after result")

endmodule

`default_nettype wire

FILE: sv/sdx_out_stage.sv
// ----------------------------------------------------------------------------
// sdx_out_stage
// Result register: holds one code until the receiver takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module sdx_out_stage import sdx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire sdx_result_t res,
  output logic             space,
  sdx_out_if.source        out_bus
);

  logic        valid_r;
  logic        valid_nxt;
  sdx_result_t res_r;

  assign space = !valid_r || out_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_bus.valid      = valid_r;
  assign out_bus.letter     = res_r.letter;
  assign out_bus.code_one   = res_r.code_one;
  assign out_bus.code_two   = res_r.code_two;
  assign out_bus.code_three = res_r.code_three;

endmodule

`default_nettype wire
